[hdl/grd_pkg.sv]
// grd_pkg: shared types and constants of the grid ray caster
// used by the interface file and every module in hdl

package grd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CellW  = 6;
  localparam int unsigned HeightW = 10;
  localparam logic [HeightW-1:0] HeightReset = 10'd600;

  localparam logic [1:0] StatusHit   = 2'd0;
  localparam logic [1:0] StatusMiss  = 2'd1;
  localparam logic [1:0] StatusWrite = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic [CoordW-1:0]        origin_x;
    logic [CoordW-1:0]        origin_y;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic [CellW-1:0]         cell_x;
    logic [CellW-1:0]         cell_y;
    logic                     wall_bit;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              hit_side;
    logic [31:0]       perp_distance;
    logic [HeightW-1:0] span_start;
    logic [HeightW-1:0] span_end;
    logic signed [7:0] hit_cell_x;
    logic signed [7:0] hit_cell_y;
  } rsp_t;

  // control between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[hdl/grd_if.sv]
// grd_if: valid/ready channels for request and response beats
// depends on grd_pkg

interface grd_req_if;
  logic          valid;
  logic          ready;
  grd_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grd_rsp_if;
  logic          valid;
  logic          ready;
  grd_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/grd_div.sv]
// grd_div: radix-2 restoring divider, 64-bit quotient, one bit per cycle
// depends on grd_pkg

module grd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grd_pkg::div_ctl_t ctl_i,
  input  logic [63:0]       num_i,
  input  logic [31:0]       den_i,
  output grd_pkg::div_sts_t sts_o,
  output logic [63:0]       quo_o
);

  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[31:0], quo_q[63]};
    if (ctl_i.start) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign quo_o = quo_q;
  assign sts_o = '{busy: busy_q, done: done_q};

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q && $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("div done w/o busy");

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) busy_q && cnt_q != 7'd1 && !ctl_i.start |=> busy_q;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("div stopped early");

  property p_quo_bound;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> rem_q < {1'b0, den_q};
  endproperty
  a_quo_bound: assert property (p_quo_bound) else $error("div remainder too large");

endmodule

[hdl/grid_raycast_dda.sv]
// grid_raycast_dda: top level of the grid ray caster, sequencer and wall bitmap
// depends on grd_pkg, grd_if and grd_div
// map write: the write state writes the bitmap cell and registers the result valid
// ray cast: two divisions for the step distances (a zero operand skips its division),
// then per grid step the states step, bitmap read and test; on a hit a third division
// gives the line height (skipped for a zero distance), on a miss after MAX_STEPS steps none
// one beat in flight at a time; in_ready only in idle with the result taken
// after reset a clearing pass zeroes all MAP_DIM*MAP_DIM bitmap cells, no beat accepted
// screen_height resets to 600

module grid_raycast_dda #(
  parameter int unsigned MAP_DIM   = 64,
  parameter int unsigned MAX_STEPS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [grd_pkg::HeightW-1:0] cfg_wdata_i,
  grd_req_if.sink   in_i,
  grd_rsp_if.source out_o
);

  localparam int unsigned AW = $clog2(MAP_DIM * MAP_DIM);
  localparam int unsigned MW = $clog2(MAP_DIM);
  localparam int unsigned SW = $clog2(MAX_STEPS + 1);
  localparam int unsigned Depth = MAP_DIM * MAP_DIM;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_DIVX, S_DIVY, S_FIRST, S_STEP, S_TEST,
    S_PERP, S_DIVH, S_SPAN, S_OUT
  } state_e;

  state_e state_q;

  // bitmap
  logic           mem [Depth];
  logic [AW-1:0]  waddr;
  logic           wdata, wen;
  logic [AW-1:0]  raddr;
  logic           rdata_q;
  logic [AW:0]    clr_q;

  logic [grd_pkg::HeightW-1:0] height_q;

  // ray state
  grd_pkg::req_t req_q;
  logic [63:0]   ddx_q, ddy_q, distx_q, disty_q;
  logic signed [9:0] mx_q, my_q;
  logic          side_q;
  logic [SW-1:0] steps_q;
  logic [31:0]   perp_q;
  logic [10:0]   lh_q;
  logic          out_valid_q;
  grd_pkg::rsp_t rsp_q;

  // divider
  grd_pkg::div_ctl_t div_ctl;
  grd_pkg::div_sts_t div_sts;
  logic [63:0] div_num, div_quo;
  logic [31:0] div_den;
  logic        div_started_q;

  grd_div u_div (
    .clk_i, .rst_ni, .ctl_i(div_ctl), .num_i(div_num), .den_i(div_den),
    .sts_o(div_sts), .quo_o(div_quo)
  );

  logic [15:0] adx, ady;
  assign adx = req_q.dir_x[15] ? 16'(-req_q.dir_x) : req_q.dir_x;
  assign ady = req_q.dir_y[15] ? 16'(-req_q.dir_y) : req_q.dir_y;

  logic [10:0] hh;
  assign hh = (height_q < 10'd2) ? 11'd2 : {1'b0, height_q};

  // divider operand mux, chosen by state; a zero divisor never starts the divider
  always_comb begin
    div_num = 64'd1 << 30;
    div_den = {16'd0, adx};
    case (state_q)
      S_DIVY: div_den = {16'd0, ady};
      S_DIVH: begin
        div_num = {37'd0, hh, 16'd0};
        div_den = perp_q;
      end
      default: ;
    endcase
    div_ctl.start = !div_started_q && ((state_q == S_DIVX && adx != 16'd0) ||
                    (state_q == S_DIVY && ady != 16'd0) ||
                    (state_q == S_DIVH && perp_q != 32'd0));
  end

  // first boundary terms
  logic [10:0] fx, fy;
  assign fx = req_q.dir_x[15] ? {1'b0, req_q.origin_x[9:0]} : 11'd1024 - req_q.origin_x[9:0];
  assign fy = req_q.dir_y[15] ? {1'b0, req_q.origin_y[9:0]} : 11'd1024 - req_q.origin_y[9:0];

  logic take_x;
  assign take_x = distx_q < disty_q;
  logic signed [9:0] nmx, nmy;
  assign nmx = take_x ? (req_q.dir_x[15] ? mx_q - 10'sd1 : mx_q + 10'sd1) : mx_q;
  assign nmy = take_x ? my_q : (req_q.dir_y[15] ? my_q - 10'sd1 : my_q + 10'sd1);

  logic outside;
  assign outside = mx_q < 0 || my_q < 0 || mx_q >= $signed(10'(MAP_DIM)) ||
                   my_q >= $signed(10'(MAP_DIM));
  assign raddr = AW'(my_q[MW-1:0]) * AW'(MAP_DIM) + AW'(mx_q[MW-1:0]);

  logic in_acc, out_acc;
  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data = rsp_q;

  assign wen = (state_q == S_CLEAR) ||
               (state_q == S_WRITE && req_q.cell_x < MAP_DIM && req_q.cell_y < MAP_DIM);
  assign waddr = (state_q == S_CLEAR) ? clr_q[AW-1:0] :
                 AW'(req_q.cell_y) * AW'(MAP_DIM) + AW'(req_q.cell_x);
  assign wdata = (state_q == S_CLEAR) ? 1'b0 : req_q.wall_bit;

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [63:0] perp_full;
  assign perp_full = side_q ? disty_q - ddy_q : distx_q - ddx_q;
  logic [10:0] st, en;
  assign st = (lh_q[10:1] > hh[10:1]) ? 11'd0 : {1'b0, hh[10:1]} - {1'b0, lh_q[10:1]};
  assign en = ({1'b0, lh_q[10:1]} + {1'b0, hh[10:1]} >= hh) ? hh - 11'd1 :
              {1'b0, lh_q[10:1]} + {1'b0, hh[10:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; height_q <= grd_pkg::HeightReset;
      out_valid_q <= 1'b0; div_started_q <= 1'b0; steps_q <= '0;
    end else begin
      if (cfg_we_i) height_q <= cfg_wdata_i;
      if (out_acc) out_valid_q <= 1'b0;
      if (div_ctl.start) div_started_q <= 1'b1;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(Depth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (in_acc) begin
          req_q <= in_i.data;
          mx_q <= 10'(in_i.data.origin_x[15:10]);
          my_q <= 10'(in_i.data.origin_y[15:10]);
          steps_q <= '0;
          state_q <= in_i.data.mode ? S_DIVX : S_WRITE;
        end
        S_WRITE: begin
          rsp_q <= '{status: grd_pkg::StatusWrite, default: '0};
          out_valid_q <= 1'b1; state_q <= S_IDLE;
        end
        S_DIVX: begin
          if (adx == 16'd0) begin
            ddx_q <= 64'd1 << 48; div_started_q <= 1'b0; state_q <= S_DIVY;
          end else if (div_sts.done) begin
            ddx_q <= div_quo; div_started_q <= 1'b0; state_q <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (ady == 16'd0) begin
            ddy_q <= 64'd1 << 48; div_started_q <= 1'b0; state_q <= S_FIRST;
          end else if (div_sts.done) begin
            ddy_q <= div_quo; div_started_q <= 1'b0; state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          distx_q <= (64'(fx) * ddx_q) >> 10;
          disty_q <= (64'(fy) * ddy_q) >> 10;
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (steps_q == SW'(MAX_STEPS)) begin
            rsp_q <= '{status: grd_pkg::StatusMiss, default: '0};
            out_valid_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            if (take_x) distx_q <= distx_q + ddx_q;
            else disty_q <= disty_q + ddy_q;
            side_q <= !take_x;
            mx_q <= nmx; my_q <= nmy;
            steps_q <= steps_q + 1'b1;
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          // the cell at mx_q,my_q is registered into rdata_q as this state ends
          state_q <= S_PERP;
        end
        S_PERP: begin
          if (outside || rdata_q) begin
            perp_q <= (perp_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : perp_full[31:0];
            state_q <= S_DIVH;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_DIVH: begin
          if (perp_q == 32'd0) begin
            lh_q <= hh; div_started_q <= 1'b0; state_q <= S_SPAN;
          end else if (div_sts.done) begin
            lh_q <= (div_quo > 64'd2047) ? 11'd2047 : div_quo[10:0];
            div_started_q <= 1'b0; state_q <= S_SPAN;
          end
        end
        S_SPAN: begin
          rsp_q.status <= grd_pkg::StatusHit;
          rsp_q.hit_side <= side_q;
          rsp_q.perp_distance <= perp_q;
          rsp_q.span_start <= st[9:0];
          rsp_q.span_end <= en[9:0];
          rsp_q.hit_cell_x <= mx_q[7:0];
          rsp_q.hit_cell_y <= my_q[7:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_ready_idle;
    @(posedge clk_i) disable iff (!rst_ni) in_i.ready |-> !out_valid_q && state_q == S_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  property p_steps_bound;
    @(posedge clk_i) disable iff (!rst_ni) steps_q <= SW'(MAX_STEPS);
  endproperty
  a_steps_bound: assert property (p_steps_bound) else $error("step count overflow");

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_q && !out_o.ready |=> $stable(rsp_q);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while pending");

endmodule
